// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared constants for the even-odd point-in-polygon test.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Default coordinate width in bits (two's complement).
    localparam int COORD_WIDTH_DEF = 16;

    // Number of edge descriptors the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 4;

    // Output tdata width: one flag, filled up to a whole byte.
    localparam int OUT_TDATA_WIDTH = 8;

endpackage

// ===== rtl/pip_queue.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon descriptor queue
// Small register FIFO that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module pip_queue
    import pip_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/pip_front.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon front end
// Keeps query, start and previous vertex; turns each vertex into edge terms.
// ----------------------------------------------------------------------------
module pip_front
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ENTRY_WIDTH = 2 * (1 + 4 * (COORD_WIDTH + 1)) + 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [4*COORD_WIDTH-1:0] in_coords,
    input  logic                     in_first,
    input  logic                     in_last,
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [ENTRY_WIDTH-1:0]   push_data
);

    localparam int W  = COORD_WIDTH;
    localparam int D  = W + 1;
    localparam int EW = 1 + 4 * D;

    logic signed [W-1:0] point_x_reg, point_y_reg;
    logic signed [W-1:0] start_x_reg, start_y_reg;
    logic signed [W-1:0] prev_x_reg,  prev_y_reg;

    logic signed [W-1:0] vx, vy, qx, qy;
    logic signed [W-1:0] px_cl, py_cl, sx_cl, sy_cl;
    logic [EW-1:0]       edge_cur;
    logic [EW-1:0]       edge_close;
    logic                accept;

    // Edge terms: {active, py-yi, xj-xi, px-xi, yj-yi}. Active means the edge
    // straddles the query y and has an end at or left of the query x.
    function automatic logic [EW-1:0] edge_terms(
        input logic signed [W-1:0] xi,
        input logic signed [W-1:0] yi,
        input logic signed [W-1:0] xj,
        input logic signed [W-1:0] yj,
        input logic signed [W-1:0] px,
        input logic signed [W-1:0] py
    );
        logic              straddle;
        logic              left;
        logic signed [D-1:0] a, b, c, d;
        straddle = ((yi < py) && (yj >= py)) || ((yj < py) && (yi >= py));
        left     = (xi <= px) || (xj <= px);
        a = D'(py) - D'(yi);
        b = D'(xj) - D'(xi);
        c = D'(px) - D'(xi);
        d = D'(yj) - D'(yi);
        return {straddle && left, a, b, c, d};
    endfunction

    assign vx = in_coords[W-1:0];
    assign vy = in_coords[2*W-1:W];
    assign qx = in_coords[3*W-1:2*W];
    assign qy = in_coords[4*W-1:3*W];

    // A first vertex that is also last closes against itself with the new query.
    assign px_cl = in_first ? qx : point_x_reg;
    assign py_cl = in_first ? qy : point_y_reg;
    assign sx_cl = in_first ? vx : start_x_reg;
    assign sy_cl = in_first ? vy : start_y_reg;

    assign edge_cur   = edge_terms(vx, vy, prev_x_reg, prev_y_reg, point_x_reg, point_y_reg);
    assign edge_close = edge_terms(sx_cl, sy_cl, vx, vy, px_cl, py_cl);

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    assign push_data = {in_last, in_first,
                        in_last && edge_close[EW-1], edge_close[EW-2:0],
                        !in_first && edge_cur[EW-1], edge_cur[EW-2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg <= '0;
            point_y_reg <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end
        else if (accept)
        begin
            if (in_first)
            begin
                point_x_reg <= qx;
                point_y_reg <= qy;
                start_x_reg <= vx;
                start_y_reg <= vy;
            end
            prev_x_reg <= vx;
            prev_y_reg <= vy;
        end
    end

endmodule

// ===== rtl/pip_back.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon back end
// Cross-multiplies edge terms, compares, keeps the parity and emits the flag.
// ----------------------------------------------------------------------------
module pip_back
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ENTRY_WIDTH = 2 * (1 + 4 * (COORD_WIDTH + 1)) + 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [ENTRY_WIDTH-1:0] pop_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_inside
);

    localparam int D  = COORD_WIDTH + 1;
    localparam int EW = 1 + 4 * D;
    localparam int PW = 2 * D;

    logic                 en;
    logic                 mul_valid_reg;
    logic                 mul_first_reg;
    logic                 mul_last_reg;
    logic [1:0]           mul_act_reg;
    logic [1:0]           mul_dneg_reg;
    logic signed [PW-1:0] mul_ab_reg [2];
    logic signed [PW-1:0] mul_cd_reg [2];
    logic [1:0]           flip;
    logic                 parity_reg;
    logic                 parity_mid;
    logic                 parity_next;
    logic                 out_valid_reg;
    logic                 out_inside_reg;

    // Whole back end moves together unless a finished flag is still waiting.
    assign en        = !out_valid_reg || out_ready;
    assign pop_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= pop_valid;
        end
    end

    for (genvar k = 0; k < 2; k++)
    begin : g_edge
        logic [EW-1:0]       ent;
        logic signed [D-1:0] a, b, c, d;
        assign ent = pop_data[k*EW +: EW];
        assign a   = ent[4*D-1:3*D];
        assign b   = ent[3*D-1:2*D];
        assign c   = ent[2*D-1:D];
        assign d   = ent[D-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mul_act_reg[k]  <= ent[EW-1];
                mul_dneg_reg[k] <= d[D-1];
                mul_ab_reg[k]   <= a * b;
                mul_cd_reg[k]   <= c * d;
            end
        end

        // Reversed comparison for an edge that runs downwards.
        assign flip[k] = mul_act_reg[k] &&
                         (mul_dneg_reg[k] ? (mul_cd_reg[k] < mul_ab_reg[k])
                                          : (mul_ab_reg[k] < mul_cd_reg[k]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_first_reg <= pop_data[ENTRY_WIDTH-2];
            mul_last_reg  <= pop_data[ENTRY_WIDTH-1];
        end
    end

    assign parity_mid  = (mul_first_reg ? 1'b0 : parity_reg) ^ flip[0];
    assign parity_next = parity_mid ^ flip[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= mul_valid_reg && mul_last_reg;
            if (mul_valid_reg)
            begin
                parity_reg <= parity_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_inside_reg <= parity_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_inside = out_inside_reg;

endmodule

// ===== rtl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Even-odd crossing test over a stream of polygon vertices.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Contents
//  s_*      in         s_tvalid / s_tready  one vertex per transaction; query
//                                           point on the first, tuser = first,
//                                           tlast = last vertex
//  m_*      out        m_tvalid / m_tready  inside flag, one transaction per
//                                           polygon, sent after its last vertex
//
// One vertex is taken per cycle while the queue has room. Each transaction passes
// the front end and is written into the queue at the edge that accepts it. From
// there it moves to the multiplier stage and then to the compare, parity and
// output stage, whose register holds the inside flag once the last vertex has
// passed through.
// Reset is asynchronous and active low; it clears the held query, start and
// previous vertex, the parity and all valid flags.
// A stalled output holds the back end; the four-entry queue keeps the input
// open until it fills.
//
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // vertex_x, vertex_y, query_x, query_y (lowest bits first), zero-filled
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    // first_vertex
    input  logic                                      s_tuser,
    // last_vertex
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // inside_res in bit 0, rest zero
    output logic [OUT_TDATA_WIDTH-1:0]                m_tdata
);

    // Per queue entry: the current and the closing edge, each {active, four
    // terms of COORD_WIDTH+1 bits}, then the first and last markers.
    localparam int ENTRY_WIDTH = 2 * (1 + 4 * (COORD_WIDTH + 1)) + 2;

    logic                   push_valid;
    logic                   push_ready;
    logic [ENTRY_WIDTH-1:0] push_data;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [ENTRY_WIDTH-1:0] pop_data;
    logic                   inside_flag;

    // Front end: holds the polygon context and forms the terms of the edge
    // ending at this vertex and, on the last vertex, of the closing edge.
    pip_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_coords  (s_tdata[4*COORD_WIDTH-1:0]),
        .in_first   (s_tuser),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pip_queue #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: exact cross-multiplication in place of the crossing division,
    // then the parity update and the output register.
    pip_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_inside (inside_flag)
    );

    assign m_tdata = {{(OUT_TDATA_WIDTH-1){1'b0}}, inside_flag};

endmodule
